// ===== rtl/core/dvp_pkg.sv =====
// Package for the dead reckoning valve position unit.
// Item types, opcodes, register indexes, FSM states, control/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dvp_pkg;

    localparam int CNT_W  = 16;
    localparam int STEP_W = 8;
    localparam int PCT_W  = 7;

    // divider: 24-bit dividend, 16-bit divisor, divisor pre-shift up to 23
    localparam int DIV_DW = 24;
    localparam int DIV_SW = 40;
    localparam int DIV_NW = 5;

    localparam logic [CNT_W-1:0]  MAX_TICK_COUNT = 16'hFFFF;
    localparam logic [PCT_W-1:0]  PCT_FULL       = 7'd100;
    localparam logic [PCT_W-1:0]  PREC_OK_MAX    = 7'd25;
    localparam logic [CNT_W-1:0]  RATIO_MIN      = 16'd8;
    localparam logic [STEP_W-1:0] MIN_STEP_RESET = 8'd31;

    localparam logic [DIV_NW-1:0] DIV_N_SMALL = 5'd7;
    localparam logic [DIV_NW-1:0] DIV_N_REV   = 5'd16;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_TRAVEL_CLOSE = 2'd0,
        REG_TRAVEL_OPEN  = 2'd1,
        REG_MIN_STEP     = 2'd2
    } dvp_reg_t;

    typedef enum logic [1:0] {
        OP_TICK          = 2'd0,
        OP_RECONCILE     = 2'd1,
        OP_PRESET_OPEN   = 2'd2,
        OP_PRESET_CLOSED = 2'd3
    } dvp_op_t;

    typedef struct packed {
        logic [1:0] op;
        logic       opening;
    } dvp_in_t;

    typedef struct packed {
        logic [PCT_W-1:0] percent_open;
        logic [PCT_W-1:0] precision_pct;
        logic             calib_ok;
        logic [CNT_W-1:0] closing_ticks;
    } dvp_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_PREC,
        ST_EVAL,
        ST_REV,
        ST_MUL,
        ST_SUB,
        ST_PCT,
        ST_PCTW,
        ST_OUT
    } dvp_state_t;

    typedef struct packed {
        logic tick;
        logic preset_open;
        logic preset_closed;
        logic prep;
        logic eval;
        logic rev_latch;
        logic mul;
        logic sub;
        logic pct_start;
        logic load_out;
    } dvp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic shift_done;
        logic os_zero;
    } dvp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/dvp_regs.sv =====
// APB configuration registers: travel counts and minimum step.
// Depends on dvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvp_regs import dvp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [CNT_W-1:0]  travel_close,
    output logic      [CNT_W-1:0]  travel_open,
    output logic      [STEP_W-1:0] min_step
);

    logic [CNT_W-1:0]  tc_reg, tc_next;
    logic [CNT_W-1:0]  to_reg, to_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              wr_en;
    logic [1:0]        idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[3:2];

    always_comb begin
        tc_next   = tc_reg;
        to_next   = to_reg;
        step_next = step_reg;
        if (wr_en) begin
            case (idx)
                REG_TRAVEL_CLOSE: tc_next   = pwdata[CNT_W-1:0];
                REG_TRAVEL_OPEN:  to_next   = pwdata[CNT_W-1:0];
                REG_MIN_STEP:     step_next = pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg   <= '0;
            to_reg   <= '0;
            step_reg <= MIN_STEP_RESET;
        end else begin
            tc_reg   <= tc_next;
            to_reg   <= to_next;
            step_reg <= step_next;
        end
    end

    always_comb begin
        case (idx)
            REG_TRAVEL_CLOSE: prdata = APB_DW'(tc_reg);
            REG_TRAVEL_OPEN:  prdata = APB_DW'(to_reg);
            REG_MIN_STEP:     prdata = APB_DW'(step_reg);
            default:          prdata = '0;
        endcase
    end

    assign travel_close = tc_reg;
    assign travel_open  = to_reg;
    assign min_step     = step_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dvp_div.sv =====
// Restoring divider, one quotient bit per cycle, step count set per start.
// Quotient must fit in nbits bits. Depends on dvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvp_div import dvp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_DW-1:0] dividend,
    input  wire logic [CNT_W-1:0]  divisor,
    input  wire logic [DIV_NW-1:0] nbits,
    output logic                   busy,
    output logic      [DIV_DW-1:0] quot,
    output logic      [DIV_DW-1:0] rem
);

    logic              busy_reg, busy_next;
    logic [DIV_NW-1:0] cnt_reg, cnt_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] quot_reg, quot_next;
    logic [DIV_SW-1:0] dsh_reg, dsh_next;
    logic              fits;

    assign fits = DIV_SW'(rem_reg) >= dsh_reg;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dsh_next  = dsh_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = nbits;
            rem_next  = dividend;
            quot_next = '0;
            dsh_next  = DIV_SW'(divisor) << (nbits - 1'b1);
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg[DIV_DW-1:0];
            end
            quot_next = {quot_reg[DIV_DW-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_NW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dsh_reg  <= dsh_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dvp_datapath.sv =====
// Datapath: tick counters, ratio reduction, precision, reconcile, percent open.
// Depends on dvp_pkg and dvp_div.
`timescale 1ns / 1ps
`default_nettype none

module dvp_datapath import dvp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dvp_in_t           s_item,
    input  wire dvp_cmd_t          cmd,
    input  wire logic [CNT_W-1:0]  travel_close,
    input  wire logic [CNT_W-1:0]  travel_open,
    input  wire logic [STEP_W-1:0] min_step,
    output dvp_sts_t               sts,
    output dvp_out_t               m_item
);

    logic [CNT_W-1:0]  closing_reg, closing_next;
    logic [CNT_W-1:0]  reverse_reg, reverse_next;
    logic [CNT_W-1:0]  lo_reg;
    logic              cap_reg;
    logic [CNT_W-1:0]  c_reg, c_next;
    logic [CNT_W-1:0]  o_reg, o_next;
    logic [PCT_W-1:0]  prec_reg;
    logic              ok_reg;
    logic [CNT_W-1:0]  blocks_reg;
    logic [DIV_DW-1:0] prod_reg;
    logic              zero_reg;
    logic              ge_reg;
    dvp_out_t          out_reg;

    logic [CNT_W-1:0]  lo_val;
    logic [22:0]       step_x128;
    logic [22:0]       lo_x100;
    logic [CNT_W-1:0]  max_co;
    logic [CNT_W-1:0]  min_co;
    logic              shift_need;
    logic [PCT_W-1:0]  prec_val;
    logic [PCT_W-1:0]  pct_val;

    logic              div_start;
    logic [DIV_DW-1:0] div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic [DIV_NW-1:0] div_nbits;
    logic              div_busy;
    logic [DIV_DW-1:0] div_quot;
    logic [DIV_DW-1:0] div_rem;

    assign lo_val     = (travel_close < travel_open) ? travel_close : travel_open;
    assign step_x128  = 23'({min_step, 7'b0});
    assign lo_x100    = 23'(lo_val) * 23'(PCT_FULL);
    assign max_co     = (c_reg > o_reg) ? c_reg : o_reg;
    assign min_co     = (c_reg < o_reg) ? c_reg : o_reg;
    assign shift_need = max_co > CNT_W'(min_step);
    assign prec_val   = cap_reg ? PCT_FULL : div_quot[PCT_W-1:0];

    // divider operand select: precision, reverse blocks, percent open
    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIV_DW'(step_x128);
        div_divisor  = lo_val;
        div_nbits    = DIV_N_SMALL;
        if (cmd.prep) begin
            div_start = 1'b1;
        end else if (cmd.eval) begin
            div_start    = (o_reg != '0);
            div_dividend = DIV_DW'(reverse_reg);
            div_divisor  = o_reg;
            div_nbits    = DIV_N_REV;
        end else if (cmd.pct_start) begin
            div_start    = 1'b1;
            div_dividend = DIV_DW'(travel_close - closing_reg) * DIV_DW'(PCT_FULL);
            div_divisor  = travel_close;
            div_nbits    = DIV_N_SMALL;
        end
    end

    dvp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .nbits    (div_nbits),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // counters
    always_comb begin
        closing_next = closing_reg;
        reverse_next = reverse_reg;
        if (cmd.tick) begin
            if (!s_item.opening) begin
                if (closing_reg < MAX_TICK_COUNT) closing_next = closing_reg + 1'b1;
            end else begin
                if (reverse_reg < MAX_TICK_COUNT) reverse_next = reverse_reg + 1'b1;
            end
        end else if (cmd.preset_open) begin
            closing_next = '0;
            reverse_next = '0;
        end else if (cmd.preset_closed) begin
            closing_next = travel_close;
            reverse_next = '0;
        end else if (cmd.rev_latch) begin
            reverse_next = div_rem[CNT_W-1:0];
        end else if (cmd.sub) begin
            // whole blocks at once, floored at zero
            closing_next = (DIV_DW'(closing_reg) > prod_reg)
                         ? closing_reg - prod_reg[CNT_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closing_reg <= '0;
            reverse_reg <= '0;
        end else begin
            closing_reg <= closing_next;
            reverse_reg <= reverse_next;
        end
    end

    // ratio reduction: one shift per cycle until neither exceeds the step
    always_comb begin
        c_next = c_reg;
        o_next = o_reg;
        if (cmd.prep) begin
            c_next = travel_close;
            o_next = travel_open;
        end else if (shift_need) begin
            c_next = c_reg >> 1;
            o_next = o_reg >> 1;
        end
    end

    always_comb begin
        if (zero_reg)    pct_val = PCT_FULL;
        else if (ge_reg) pct_val = '0;
        else             pct_val = div_quot[PCT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        c_reg <= c_next;
        o_reg <= o_next;
        if (cmd.prep) begin
            lo_reg  <= lo_val;
            cap_reg <= (lo_val == '0) || (step_x128 >= lo_x100);
        end
        if (cmd.eval) begin
            prec_reg <= prec_val;
            ok_reg   <= (lo_reg != '0) && (prec_val <= PREC_OK_MAX) && (min_co >= RATIO_MIN);
        end
        if (cmd.rev_latch) begin
            blocks_reg <= div_quot[CNT_W-1:0];
        end
        if (cmd.mul) begin
            prod_reg <= DIV_DW'(blocks_reg) * DIV_DW'(c_reg[STEP_W-1:0]);
        end
        if (cmd.pct_start) begin
            zero_reg <= (closing_reg == '0);
            ge_reg   <= (closing_reg >= travel_close);
        end
        if (cmd.load_out) begin
            out_reg.percent_open  <= pct_val;
            out_reg.precision_pct <= prec_reg;
            out_reg.calib_ok      <= ok_reg;
            out_reg.closing_ticks <= closing_reg;
        end
    end

    assign sts.div_busy   = div_busy;
    assign sts.shift_done = !shift_need;
    assign sts.os_zero    = (o_reg == '0);
    assign m_item         = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dvp_ctrl.sv =====
// Controller FSM: sequences reconcile steps and owns both handshakes.
// Depends on dvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvp_ctrl import dvp_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [1:0] s_op,
    input  wire logic       m_ready,
    input  wire dvp_sts_t   sts,
    output logic            s_ready,
    output logic            m_valid,
    output dvp_cmd_t        cmd
);

    dvp_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;
    logic       out_free;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_op == OP_RECONCILE)) state_next = ST_PREP;
            end
            ST_PREP: state_next = ST_PREC;
            ST_PREC: begin
                if (!sts.div_busy && sts.shift_done) state_next = ST_EVAL;
            end
            ST_EVAL: state_next = sts.os_zero ? ST_PCT : ST_REV;
            ST_REV: begin
                if (!sts.div_busy) state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_SUB;
            ST_SUB:  state_next = ST_PCT;
            ST_PCT:  state_next = ST_PCTW;
            ST_PCTW: begin
                if (!sts.div_busy) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd               = '0;
        s_ready           = (state_reg == ST_IDLE);
        cmd.tick          = accept && (s_op == OP_TICK);
        cmd.preset_open   = accept && (s_op == OP_PRESET_OPEN);
        cmd.preset_closed = accept && (s_op == OP_PRESET_CLOSED);
        cmd.prep          = (state_reg == ST_PREP);
        cmd.eval          = (state_reg == ST_EVAL);
        cmd.rev_latch     = (state_reg == ST_REV) && !sts.div_busy;
        cmd.mul           = (state_reg == ST_MUL);
        cmd.sub           = (state_reg == ST_SUB);
        cmd.pct_start     = (state_reg == ST_PCT);
        cmd.load_out      = (state_reg == ST_OUT) && out_free;
    end

    always_comb begin
        if (cmd.load_out)  m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
        else               m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_div_free_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.prep || cmd.pct_start) |-> !sts.div_busy)
        else $error("divider started while busy");

    a_eval_after_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> sts.shift_done)
        else $error("ratio used before reduction finished");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_OUT) && !out_free) |=> (state_reg == ST_OUT))
        else $error("result dropped while output stalled");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg)
        else $error("result loaded without valid");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/dead_reckoning_valve_position_unit.sv =====
// Tick, preset-open and preset-closed items: no result, taken back to back.
// Reconcile item: the shared divider (7, 16 and 7 bit steps) and the ratio shifter (up to 16
// steps, beside the first divide) set the time from accept to m_valid; the reverse step is
// skipped when the reduced open ratio is zero. s_ready returns with m_valid.
// One item at a time; a pending result does not block new items until the next result is due.
// Reset: aresetn synchronous, active low; counters zero, travel counts zero, min step 31.
`timescale 1ns / 1ps
`default_nettype none

module dead_reckoning_valve_position_unit import dvp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // item input
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire dvp_in_t           s_data,
    // result output
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dvp_out_t               m_data,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic [CNT_W-1:0]  travel_close;
    logic [CNT_W-1:0]  travel_open;
    logic [STEP_W-1:0] min_step;
    dvp_cmd_t          cmd;
    dvp_sts_t          sts;

    // config registers; to be written only while idle, which the block itself does not enforce
    dvp_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .travel_close (travel_close),
        .travel_open  (travel_open),
        .min_step     (min_step)
    );

    // sequencer: decodes ops, steps reconcile, owns valid/ready
    dvp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .m_ready (m_ready),
        .sts     (sts),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    // counters, derived calibration values, divider, result register
    dvp_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_item       (s_data),
        .cmd          (cmd),
        .travel_close (travel_close),
        .travel_open  (travel_open),
        .min_step     (min_step),
        .sts          (sts),
        .m_item       (m_data)
    );

endmodule

`default_nettype wire

// ===== test/dead_reckoning_valve_position_unit_test.sv =====
// Self-checking testbench for the dead reckoning valve position unit.
// A directed table, then randomized phases with APB recalibration between them.
// Depends on dvp_pkg and dead_reckoning_valve_position_unit.
`timescale 1ns / 1ps

module dead_reckoning_valve_position_unit_test;
    import dvp_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    // leave headroom for a reconcile to finish before touching registers
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 205;
    localparam int MAX_REPORTS   = 10;

    // register i sits at byte address 4*i
    localparam logic [APB_AW-1:0] ADDR_TRAVEL_CLOSE = {REG_TRAVEL_CLOSE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_TRAVEL_OPEN  = {REG_TRAVEL_OPEN, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_MIN_STEP     = {REG_MIN_STEP, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED     = 4'd12;

    // end-stop calibration values used by the extreme-setting phases
    localparam logic [CNT_W-1:0]  TRAVEL_EXTREMES [3] = '{16'd0, 16'd1, 16'hFFFF};
    localparam logic [STEP_W-1:0] STEP_EXTREMES   [3] = '{8'd0, 8'd1, 8'd255};

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    // a report typed straight into the table, or left to the position tracker
    typedef struct packed {
        logic     pinned;
        dvp_out_t report;
    } pinned_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [APB_AW-1:0] addr;
        logic [APB_DW-1:0] wdata;
        dvp_in_t           item;
        logic              pinned;
        dvp_out_t          report;
    } directed_row_t;

    localparam dvp_in_t  NO_ITEM   = '0;
    localparam dvp_out_t NO_REPORT = '0;
    localparam int NUM_DIRECTED = 27;

    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // reset state: no travel, counters empty
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_RECONCILE, 1'b0}, 1'b1, '{7'd100, 7'd100, 1'b0, 16'd0}},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_TICK, 1'b0}, 1'b0, NO_REPORT},
        // zero travel with a nonzero count reads fully closed
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_RECONCILE, 1'b0}, 1'b1, '{7'd0, 7'd100, 1'b0, 16'd1}},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_PRESET_OPEN, 1'b1}, 1'b0, NO_REPORT},
        // small calibration: ratios reduce to 4:2, so two reverse ticks back out four
        '{ROW_WRITE, ADDR_TRAVEL_CLOSE, 32'd16, NO_ITEM, 1'b0, NO_REPORT},
        '{ROW_WRITE, ADDR_TRAVEL_OPEN, 32'd8, NO_ITEM, 1'b0, NO_REPORT},
        '{ROW_WRITE, ADDR_MIN_STEP, 32'd4, NO_ITEM, 1'b0, NO_REPORT},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_PRESET_CLOSED, 1'b0}, 1'b0, NO_REPORT},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_TICK, 1'b1}, 1'b0, NO_REPORT},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_TICK, 1'b1}, 1'b0, NO_REPORT},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_TICK, 1'b1}, 1'b0, NO_REPORT},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_RECONCILE, 1'b1}, 1'b0, NO_REPORT},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_TICK, 1'b0}, 1'b0, NO_REPORT},
        // zero step: ratios collapse, reverse subtraction skipped
        '{ROW_WRITE, ADDR_MIN_STEP, 32'd0, NO_ITEM, 1'b0, NO_REPORT},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_RECONCILE, 1'b0}, 1'b0, NO_REPORT},
        // full-scale calibration, upper data bits set
        '{ROW_WRITE, ADDR_TRAVEL_CLOSE, 32'hFFFF_FFFF, NO_ITEM, 1'b0, NO_REPORT},
        '{ROW_WRITE, ADDR_TRAVEL_OPEN, 32'hFFFF_FFFF, NO_ITEM, 1'b0, NO_REPORT},
        '{ROW_WRITE, ADDR_MIN_STEP, 32'hFFFF_FFFF, NO_ITEM, 1'b0, NO_REPORT},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_PRESET_CLOSED, 1'b1}, 1'b0, NO_REPORT},
        // closing counter already saturated
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_TICK, 1'b0}, 1'b0, NO_REPORT},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_RECONCILE, 1'b0}, 1'b1, '{7'd0, 7'd0, 1'b1, 16'hFFFF}},
        // write past the register map must be dropped
        '{ROW_WRITE, ADDR_UNMAPPED, 32'h1234_5678, NO_ITEM, 1'b0, NO_REPORT},
        '{ROW_WRITE, ADDR_TRAVEL_OPEN, 32'd0, NO_ITEM, 1'b0, NO_REPORT},
        '{ROW_WRITE, ADDR_MIN_STEP, 32'd1, NO_ITEM, 1'b0, NO_REPORT},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_RECONCILE, 1'b1}, 1'b1, '{7'd0, 7'd100, 1'b0, 16'hFFFF}},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_PRESET_OPEN, 1'b0}, 1'b0, NO_REPORT},
        '{ROW_ITEM, 4'd0, 32'd0, '{OP_RECONCILE, 1'b0}, 1'b1, '{7'd100, 7'd100, 1'b0, 16'd0}}
    };

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    dvp_in_t           s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    dvp_out_t          m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // tracker copy of calibration and counters
    logic [CNT_W-1:0]  cal_close   = '0;
    logic [CNT_W-1:0]  cal_open    = '0;
    logic [STEP_W-1:0] cal_step    = MIN_STEP_RESET;
    logic [CNT_W-1:0]  est_closing = '0;
    logic [CNT_W-1:0]  est_reverse = '0;

    dvp_out_t valve_reports_q [$];
    pinned_t  pinned_q [$];

    int gap_pct        = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;
    int report_index   = 0;
    int cycle_count    = 0;

    dead_reckoning_valve_position_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    // Position tracker: applies one item to the counters, returns 1 with a report
    // for a reconcile.
    function automatic logic track_valve_position(input dvp_in_t it, output dvp_out_t report);
        int unsigned c, o, lo, step, prec, blocks, sub, pct;
        report = '0;
        case (dvp_op_t'(it.op))
            OP_TICK: begin
                // saturating counters, one per direction
                if (!it.opening) begin
                    if (est_closing < MAX_TICK_COUNT) est_closing++;
                end else begin
                    if (est_reverse < MAX_TICK_COUNT) est_reverse++;
                end
                return 1'b0;
            end
            OP_PRESET_OPEN: begin
                est_closing = '0;
                est_reverse = '0;
                return 1'b0;
            end
            OP_PRESET_CLOSED: begin
                est_closing = cal_close;
                est_reverse = '0;
                return 1'b0;
            end
            default: begin
            end
        endcase

        c    = 32'(cal_close);
        o    = 32'(cal_open);
        step = 32'(cal_step);
        lo   = (c < o) ? c : o;
        // precision: 128 * step / shorter travel, capped; zero travel reads worst
        prec = (lo == 0) ? PCT_FULL : (128 * step) / lo;
        if (prec > PCT_FULL) prec = PCT_FULL;
        // reduce both ratios together until neither exceeds the step
        while (((c > o) ? c : o) > step) begin
            c >>= 1;
            o >>= 1;
        end
        report.calib_ok = (lo != 0) && (prec <= PREC_OK_MAX) && (((c < o) ? c : o) >= RATIO_MIN);

        // back out whole reverse blocks against closing blocks, floored at zero
        if (o != 0) begin
            blocks      = est_reverse / o;
            sub         = blocks * c;
            est_reverse = CNT_W'(est_reverse - blocks * o);
            if (blocks != 0) est_closing = (est_closing > sub) ? CNT_W'(est_closing - sub) : '0;
        end

        if (est_closing == 0) pct = PCT_FULL;
        else if (est_closing >= cal_close) pct = 0;
        else pct = ((cal_close - est_closing) * 100) / cal_close;

        report.percent_open  = pct[PCT_W-1:0];
        report.precision_pct = prec[PCT_W-1:0];
        report.closing_ticks = est_closing;
        return 1'b1;
    endfunction

    // Item monitor and result checker. Samples pre-edge values only.
    always @(posedge aclk) begin
        pinned_t  pin;
        dvp_out_t predicted;
        dvp_out_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dead_reckoning_valve_position_unit: mismatch");
            $finish;
        end else if (aresetn) begin
            if (s_valid && s_ready) begin
                pin = pinned_q.pop_front();
                // tracker always runs so its counters follow the block
                if (track_valve_position(s_data, predicted))
                    valve_reports_q.push_back(pin.pinned ? pin.report : predicted);
            end
            if (m_valid && m_ready) begin
                if (valve_reports_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected report pct=%0d prec=%0d ok=%0b closing=%0d",
                                 $time, m_data.percent_open, m_data.precision_pct,
                                 m_data.calib_ok, m_data.closing_ticks);
                end else begin
                    want = valve_reports_q.pop_front();
                    if (m_data.percent_open !== want.percent_open
                            || m_data.precision_pct !== want.precision_pct
                            || m_data.calib_ok !== want.calib_ok
                            || m_data.closing_ticks !== want.closing_ticks) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $write("%0t: report %0d want pct=%0d prec=%0d ok=%0b closing=%0d,",
                                   $time, report_index, want.percent_open,
                                   want.precision_pct, want.calib_ok, want.closing_ticks);
                            $display(" got pct=%0d prec=%0d ok=%0b closing=%0d",
                                     m_data.percent_open, m_data.precision_pct,
                                     m_data.calib_ok, m_data.closing_ticks);
                        end
                    end
                end
                report_index++;
            end
        end
    end

    // Result back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Present one item, with random idle cycles ahead of it; returns at the accepting edge.
    task automatic present_item(input dvp_in_t it, input pinned_t pin);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        pinned_q.push_back(pin);
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // APB write, only once the block has gone quiet.
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        s_valid <= 1'b0;
        while (valve_reports_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_TRAVEL_CLOSE: begin
                cal_close = data[CNT_W-1:0];
            end
            ADDR_TRAVEL_OPEN: begin
                cal_open = data[CNT_W-1:0];
            end
            ADDR_MIN_STEP: begin
                cal_step = data[STEP_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // One random phase: recalibrate, then preset / tick / reconcile traffic.
    task automatic run_phase(input idle_mode_t mode);
        logic [CNT_W-1:0]  close_t;
        logic [CNT_W-1:0]  open_t;
        logic [STEP_W-1:0] step_t;
        logic [APB_DW-1:0] noise;
        dvp_in_t           it;
        pinned_t           pin;
        int                roll;
        int                open_bias;

        case ($urandom_range(0, 3))
            0: begin
                // realistic travel, short pulses: frequent block subtraction
                close_t = CNT_W'($urandom_range(20, 400));
                open_t  = CNT_W'($urandom_range(20, 400));
                step_t  = STEP_W'($urandom_range(1, 40));
            end
            1: begin
                close_t = CNT_W'($urandom_range(0, 40));
                open_t  = CNT_W'($urandom_range(0, 40));
                step_t  = STEP_W'($urandom_range(0, 15));
            end
            2: begin
                close_t = CNT_W'($urandom());
                open_t  = CNT_W'($urandom());
                step_t  = STEP_W'($urandom());
            end
            default: begin
                close_t = TRAVEL_EXTREMES[$urandom_range(0, 2)];
                open_t  = TRAVEL_EXTREMES[$urandom_range(0, 2)];
                step_t  = STEP_EXTREMES[$urandom_range(0, 2)];
            end
        endcase
        noise = $urandom();
        write_reg(ADDR_TRAVEL_CLOSE, {noise[APB_DW-1:CNT_W], close_t});
        noise = $urandom();
        write_reg(ADDR_TRAVEL_OPEN, {noise[APB_DW-1:CNT_W], open_t});
        noise = $urandom();
        write_reg(ADDR_MIN_STEP, {noise[APB_DW-1:STEP_W], step_t});

        case (mode)
            IDLE_NONE: begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                gap_pct   = 67;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                gap_pct   = 0;
                stall_pct = 67;
            end
            default: begin
                gap_pct   = 38;
                stall_pct = 38;
            end
        endcase

        // drift toward one end or the other, per phase
        open_bias = $urandom_range(25, 75);
        pin = '0;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll       = $urandom_range(0, 99);
            it.opening = 1'($urandom_range(0, 1));
            if (roll < 8) it.op = OP_RECONCILE;
            else if (roll < 10) it.op = OP_PRESET_OPEN;
            else if (roll < 12) it.op = OP_PRESET_CLOSED;
            else begin
                it.op      = OP_TICK;
                it.opening = ($urandom_range(0, 99) < open_bias);
            end
            present_item(it, pin);
        end
    endtask

    initial begin
        directed_row_t row;
        pinned_t       pin;

        aresetn <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, no idling
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.addr, row.wdata);
            end else begin
                pin.pinned = row.pinned;
                pin.report = row.report;
                present_item(row.item, pin);
            end
        end

        // random phases cycle through every idle mode twice
        for (int p = 0; p < NUM_PHASES; p++) run_phase(idle_mode_t'(p % 4));

        s_valid <= 1'b0;
        while (valve_reports_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && valve_reports_q.size() == 0)
            $display("dead_reckoning_valve_position_unit: match");
        else
            $display("dead_reckoning_valve_position_unit: mismatch");
        $finish;
    end

endmodule
